>>> rtl/gtp_pkg.sv
// Go-to-pose controller package: widths, limits, CORDIC angle table.
// No dependencies.
package gtp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_MAX        = 24;

    localparam logic [2:0] REG_GOAL_X     = 3'd0;
    localparam logic [2:0] REG_GOAL_Y     = 3'd1;
    localparam logic [2:0] REG_GOAL_HEAD  = 3'd2;
    localparam logic [2:0] REG_POS_TOL    = 3'd3;
    localparam logic [2:0] REG_HEAD_TOL   = 3'd4;
    localparam logic [2:0] REG_POS_GAIN   = 3'd5;
    localparam logic [2:0] REG_HEAD_GAIN  = 3'd6;

    localparam logic signed [25:0] VEL_LIM_Q8 = 26'sd640000;
    localparam logic signed [12:0] VEL_LIM    = 13'sd2500;
    localparam logic signed [14:0] TURN_LIM   = 15'sd10000;
    localparam logic signed [31:0] CORDIC_K   = 32'sd652032874;
    localparam logic [28:0]        TWO_PI_Q16 = 29'd411774832;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/gtp_cordic.sv
// Pipelined CORDIC sin/cos, one iteration per stage, Q30 outputs.
// Depends on gtp_pkg. Stalls with the pipeline enable.
module gtp_cordic
    import gtp_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        heading,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);

    logic signed [32:0] x_reg [STAGES+1];
    logic signed [32:0] y_reg [STAGES+1];
    logic signed [33:0] z_reg [STAGES+1];
    logic               flip_reg [STAGES+1];

    logic signed [16:0] a_fold;
    logic               flip_in;

    // fold heading into -quarter..+quarter turn
    always_comb
    begin
        a_fold  = 17'(signed'(heading));
        flip_in = 1'b0;
        if ($signed(heading) > 16'sd16384)
        begin
            a_fold  = 17'(signed'(heading)) - 17'sd32768;
            flip_in = 1'b1;
        end
        else if ($signed(heading) < -16'sd16384)
        begin
            a_fold  = 17'(signed'(heading)) + 17'sd32768;
            flip_in = 1'b1;
        end
    end

    // angle in units of 2^-32 turn: binary angle times 65536
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= 33'(CORDIC_K);
            y_reg[0]    <= '0;
            z_reg[0]    <= 34'(a_fold) <<< 16;
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [32:0] xs, ys;
        logic signed [33:0] at;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = 34'(atan_turn(5'(i)));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    logic signed [32:0] xo, yo;
    assign xo = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    assign yo = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
    assign cos_q30 = xo[31:0];
    assign sin_q30 = yo[31:0];

endmodule

>>> rtl/go_to_pose_controller.sv
// Go-to-pose controller top level: config registers, pose pipeline, output stage.
// Depends on gtp_pkg and gtp_cordic.
//
// One robot pose per clock cycle unless out_stall holds the pipeline; the
// depth is set by the CORDIC rotator, one iteration per stage.
// The whole pipeline advances when the output register is empty or being
// taken, so out_stall backpressure holds every stage in place.
module go_to_pose_controller
    import gtp_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               robot_present,
    input  logic signed [15:0] robot_x,
    input  logic signed [15:0] robot_y,
    input  logic [15:0]        robot_heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               done_res,
    output logic               drive_valid,
    output logic signed [12:0] vel_forward,
    output logic signed [12:0] vel_side,
    output logic signed [14:0] turn_rate
);

    localparam int LAT = CORDIC_STAGES + 1; // CORDIC output register depth
    localparam int NV  = LAT + 3;

    logic [15:0] goal_x_reg, goal_y_reg, goal_h_reg, pos_tol_reg;
    logic [15:0] head_tol_reg, pos_gain_reg, head_gain_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            goal_h_reg    <= '0;
            pos_tol_reg   <= 16'd100;
            head_tol_reg  <= 16'd546;
            pos_gain_reg  <= 16'd256;
            head_gain_reg <= 16'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GOAL_X:    goal_x_reg    <= cfg_data;
                REG_GOAL_Y:    goal_y_reg    <= cfg_data;
                REG_GOAL_HEAD: goal_h_reg    <= cfg_data;
                REG_POS_TOL:   pos_tol_reg   <= cfg_data;
                REG_HEAD_TOL:  head_tol_reg  <= cfg_data;
                REG_POS_GAIN:  pos_gain_reg  <= cfg_data;
                REG_HEAD_GAIN: head_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable: advance when output slot frees
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    logic [NV-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NV-2:0], in_valid};
    end

    // stage 1: differences, heading error
    logic               p1_reg;
    logic signed [16:0] dx1_reg, dy1_reg;
    logic signed [15:0] e1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= robot_present;
            dx1_reg <= 17'(signed'(goal_x_reg)) - 17'(robot_x);
            dy1_reg <= 17'(signed'(goal_y_reg)) - 17'(robot_y);
            e1_reg  <= signed'(goal_h_reg - robot_heading);
        end
    end

    // stage 2: squares, gain products, |e|
    logic               p2_reg;
    logic [33:0]        dx2sq_reg, dy2sq_reg;
    logic [31:0]        tol2_reg;
    logic signed [33:0] gvx2_reg, gvy2_reg;
    logic signed [32:0] he2_reg;
    logic [16:0]        ae2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg    <= p1_reg;
            dx2sq_reg <= 34'(dx1_reg * dx1_reg);
            dy2sq_reg <= 34'(dy1_reg * dy1_reg);
            tol2_reg  <= pos_tol_reg * pos_tol_reg;
            gvx2_reg  <= $signed({1'b0, pos_gain_reg}) * dx1_reg;
            gvy2_reg  <= $signed({1'b0, pos_gain_reg}) * dy1_reg;
            he2_reg   <= $signed({1'b0, head_gain_reg}) * e1_reg;
            ae2_reg   <= e1_reg[15] ? 17'(-18'(e1_reg)) : 17'(unsigned'(e1_reg));
        end
    end

    // stage 3: reached decision, clamp, turn product
    logic               r3_reg;
    logic signed [25:0] gvx3_reg, gvy3_reg;
    logic signed [62:0] tr3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_reg <= !p2_reg ||
                      ((35'(dx2sq_reg) + 35'(dy2sq_reg) < 35'(tol2_reg)) &&
                       (ae2_reg < 17'(head_tol_reg)));
            gvx3_reg <= (gvx2_reg > 34'(VEL_LIM_Q8)) ? VEL_LIM_Q8 :
                        (gvx2_reg < -34'(VEL_LIM_Q8)) ? -VEL_LIM_Q8 : gvx2_reg[25:0];
            gvy3_reg <= (gvy2_reg > 34'(VEL_LIM_Q8)) ? VEL_LIM_Q8 :
                        (gvy2_reg < -34'(VEL_LIM_Q8)) ? -VEL_LIM_Q8 : gvy2_reg[25:0];
            tr3_reg  <= 63'(he2_reg) * $signed({1'b0, TWO_PI_Q16});
        end
    end

    // delay line to meet the CORDIC output
    logic               r_d   [LAT-1];
    logic signed [25:0] gx_d  [LAT-1];
    logic signed [25:0] gy_d  [LAT-1];
    logic signed [14:0] tr_d  [LAT-1];
    logic signed [22:0] trs;
    logic signed [14:0] trc;
    assign trs = 23'((tr3_reg + 63'sd549755813888) >>> 40);
    assign trc = (trs > 23'(TURN_LIM)) ? TURN_LIM :
                 (trs < -23'(TURN_LIM)) ? -TURN_LIM : trs[14:0];

    // CORDIC starts from the input heading; it passes through h1_reg and h2_reg
    // so the CORDIC output lands with the stage 3 results at the delay line end
    logic [15:0] h1_reg, h2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg <= robot_heading;
            h2_reg <= h1_reg;
        end
    end

    logic signed [31:0] cos_w, sin_w;
    gtp_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk     (clk),
        .en      (en),
        .heading (h2_reg),
        .cos_q30 (cos_w),
        .sin_q30 (sin_w)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_d[0]  <= r3_reg;
            gx_d[0] <= gvx3_reg;
            gy_d[0] <= gvy3_reg;
            tr_d[0] <= trc;
            for (int k = 1; k < LAT - 1; k++)
            begin
                r_d[k]  <= r_d[k-1];
                gx_d[k] <= gx_d[k-1];
                gy_d[k] <= gy_d[k-1];
                tr_d[k] <= tr_d[k-1];
            end
        end
    end

    // rotation products (registered)
    logic               r5_reg;
    logic signed [14:0] tr5_reg;
    logic signed [57:0] gxc_reg, gys_reg, gyc_reg, gxs_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r5_reg  <= r_d[LAT-2];
            tr5_reg <= tr_d[LAT-2];
            gxc_reg <= gx_d[LAT-2] * cos_w;
            gys_reg <= gy_d[LAT-2] * sin_w;
            gyc_reg <= gy_d[LAT-2] * cos_w;
            gxs_reg <= gx_d[LAT-2] * sin_w;
        end
    end

    // sums, rounding, saturation into the output register
    logic signed [58:0] fs, ss;
    logic signed [20:0] fr, sr;
    assign fs = 59'(gxc_reg) + 59'(gys_reg) + 59'sd137438953472;
    assign ss = 59'(gyc_reg) - 59'(gxs_reg) + 59'sd137438953472;
    assign fr = 21'(fs >>> 38);
    assign sr = 21'(ss >>> 38);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= v_reg[NV-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            done_res    <= r5_reg;
            drive_valid <= !r5_reg;
            vel_forward <= r5_reg ? '0 : (fr > 21'(VEL_LIM)) ? VEL_LIM :
                           (fr < -21'(VEL_LIM)) ? -VEL_LIM : fr[12:0];
            vel_side    <= r5_reg ? '0 : (sr > 21'(VEL_LIM)) ? VEL_LIM :
                           (sr < -21'(VEL_LIM)) ? -VEL_LIM : sr[12:0];
            turn_rate   <= r5_reg ? '0 : tr5_reg;
        end
    end

    // assertions
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vel_forward))
        else $error("output changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");
    a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (done_res != drive_valid))
        else $error("done and drive both set");
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> turn_rate == 0 && vel_side == 0)
        else $error("drive nonzero on done");

endmodule
